[rtl/mdd_pkg.sv]
// mdd_pkg: shared widths, payload types and helpers of the delta event detector
// used by the channel interfaces, the ratio divider, the delta unit and the top level
`timescale 1ns / 1ps

package mdd_pkg;

  localparam int CHANNELS    = 8;
  localparam int SAMPLE_BITS = 16;
  localparam int MAX_CH      = 8;
  localparam int THR_BITS    = 16;
  localparam int CMP_BITS    = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;
  localparam int CH_IDX_BITS = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int COUNT_BITS  = 4;
  localparam int TOTAL_BITS  = 32;
  localparam int SUM_BITS    = TOTAL_BITS + 1;
  localparam int RATIO_BITS  = 17;
  localparam int DIV_STEPS   = RATIO_BITS;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);

  // configuration map
  localparam int CFG_IDX_BITS  = 4;
  localparam int CFG_DATA_BITS = THR_BITS;
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD_CH0 = CFG_IDX_BITS'(0);
  localparam int NUM_REGS = MAX_CH;

  typedef logic [MAX_CH-1:0][THR_BITS-1:0]    thr_array_t;
  typedef logic [MAX_CH-1:0][SAMPLE_BITS-1:0] samples_t;

  localparam thr_array_t THR_RESET = {
    16'd6554, 16'd6554, 16'd9830, 16'd6554, 16'd6554, 16'd3277, 16'd3277, 16'd3277
  };

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_ch7;
    logic [SAMPLE_BITS-1:0] sample_ch6;
    logic [SAMPLE_BITS-1:0] sample_ch5;
    logic [SAMPLE_BITS-1:0] sample_ch4;
    logic [SAMPLE_BITS-1:0] sample_ch3;
    logic [SAMPLE_BITS-1:0] sample_ch2;
    logic [SAMPLE_BITS-1:0] sample_ch1;
    logic [SAMPLE_BITS-1:0] sample_ch0;
  } sample_t;

  typedef struct packed {
    logic [MAX_CH-1:0]     fired_mask;
    logic [COUNT_BITS-1:0] fired_count;
    logic                  priming_item;
    logic [TOTAL_BITS-1:0] vectors_fired;
    logic [TOTAL_BITS-1:0] vectors_quiet;
    logic [RATIO_BITS-1:0] quiet_ratio;
  } result_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  function automatic samples_t unpack_samples(sample_t s);
    return samples_t'(s);
  endfunction

  function automatic logic [TOTAL_BITS-1:0] sat_inc(logic [TOTAL_BITS-1:0] v);
    return (&v) ? v : v + TOTAL_BITS'(1);
  endfunction

endpackage

[rtl/mdd_if.sv]
// mdd channel interfaces: sample input, result output and configuration write
// depends on mdd_pkg for the payload types and widths
`timescale 1ns / 1ps

interface mdd_sample_if;
  import mdd_pkg::*;
  logic    valid;
  logic    ready;
  sample_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mdd_result_if;
  import mdd_pkg::*;
  logic    valid;
  logic    ready;
  result_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mdd_cfg_if;
  import mdd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [CFG_IDX_BITS-1:0]  index;
  logic [CFG_DATA_BITS-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/multichannel_delta_event_detector.sv]
// multichannel_delta_event_detector: send-on-delta detector over eight Q0.16 channels
// depends on mdd_pkg, mdd_if, mdd_delta_unit and mdd_ratio_div
//
//   channel    dir  handshake      payload
//   sample_i   in   valid/ready    sample_ch0..sample_ch7, 16 bits each
//   result_o   out  valid/ready    mask, count, priming flag, totals, quiet ratio
//   cfg_i      in   valid/ready    register index (4 bits), threshold (16 bits)
//
// a normal vector goes through the delta unit one channel a cycle, then through
// the ratio divider one quotient bit a cycle; a priming vector skips the channel
// scan, and its zero totals let the divider finish without quotient steps
// rst_ni clears control state and loads the reset thresholds at once
// a waiting result does not block the next vector; the block stalls only when
// a second result is done before the first one is taken
`timescale 1ns / 1ps

module multichannel_delta_event_detector (
  input  logic         clk_i,
  input  logic         rst_ni,
  mdd_sample_if.sink   sample_i,
  mdd_result_if.source result_o,
  mdd_cfg_if.sink      cfg_i
);
  import mdd_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TOTALS,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_DONE
  } state_e;

  state_e                                 state_q;
  thr_array_t                             thr_q;
  logic                                   primed_q;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0]   last_q;
  samples_t                               smp_q;
  logic [CH_IDX_BITS-1:0]                 idx_q;
  logic [CHANNELS-1:0]                    mask_q;
  logic [COUNT_BITS-1:0]                  count_q;
  logic                                   priming_q;
  logic [TOTAL_BITS-1:0]                  fired_q, quiet_q;
  logic                                   out_valid_q;
  result_t                                out_q;

  samples_t              in_samples;
  logic                  in_xfer;
  logic                  out_free;
  logic                  fire;
  logic                  div_start;
  div_status_t           div_status;
  logic [RATIO_BITS-1:0] ratio;

  assign in_samples     = unpack_samples(sample_i.payload);
  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_xfer        = sample_i.valid && sample_i.ready;
  assign out_free       = !out_valid_q || result_o.ready;
  assign div_start      = (state_q == ST_DIV_START);
  assign cfg_i.ready    = 1'b1;

  mdd_delta_unit u_delta (
    .sample_i (smp_q[idx_q]),
    .last_i   (last_q[idx_q]),
    .thr_i    (thr_q[idx_q]),
    .fire_o   (fire)
  );

  mdd_ratio_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .fired_i  (fired_q),
    .quiet_i  (quiet_q),
    .status_o (div_status),
    .ratio_o  (ratio)
  );

  // thresholds, writes beyond the register list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (cfg_i.valid && cfg_i.ready &&
                 cfg_i.index < CFG_IDX_BITS'(NUM_REGS)) begin
      thr_q[3'(cfg_i.index - REG_THRESHOLD_CH0)] <= cfg_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      primed_q    <= 1'b0;
      last_q      <= '0;
      idx_q       <= '0;
      mask_q      <= '0;
      count_q     <= '0;
      priming_q   <= 1'b0;
      fired_q     <= '0;
      quiet_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            idx_q   <= '0;
            mask_q  <= '0;
            count_q <= '0;
            if (!primed_q) begin
              // first vector only loads the stored values
              for (int i = 0; i < CHANNELS; i++) begin
                last_q[i] <= in_samples[i];
              end
              primed_q  <= 1'b1;
              priming_q <= 1'b1;
              state_q   <= ST_TOTALS;
            end else begin
              priming_q <= 1'b0;
              state_q   <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          mask_q[idx_q] <= fire;
          count_q       <= count_q + COUNT_BITS'(fire);
          last_q[idx_q] <= smp_q[idx_q];
          if (idx_q == CH_IDX_BITS'(CHANNELS - 1)) begin
            state_q <= ST_TOTALS;
          end else begin
            idx_q <= idx_q + CH_IDX_BITS'(1);
          end
        end
        ST_TOTALS: begin
          if (!priming_q) begin
            if (count_q != '0) begin
              fired_q <= sat_inc(fired_q);
            end else begin
              quiet_q <= sat_inc(quiet_q);
            end
          end
          state_q <= ST_DIV_START;
        end
        ST_DIV_START: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_status.done) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      smp_q <= in_samples;
    end
    if (state_q == ST_DONE && out_free) begin
      out_q.fired_mask    <= MAX_CH'(mask_q);
      out_q.fired_count   <= count_q;
      out_q.priming_item  <= priming_q;
      out_q.vectors_fired <= fired_q;
      out_q.vectors_quiet <= quiet_q;
      out_q.quiet_ratio   <= ratio;
    end
  end

  assign result_o.valid   = out_valid_q;
  assign result_o.payload = out_q;

endmodule

[rtl/mdd_delta_unit.sv]
// mdd_delta_unit: shared absolute-difference and threshold compare for one channel
// depends on mdd_pkg for sample and threshold widths
`timescale 1ns / 1ps

module mdd_delta_unit (
  input  logic [mdd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic [mdd_pkg::SAMPLE_BITS-1:0] last_i,
  input  logic [mdd_pkg::THR_BITS-1:0]    thr_i,
  output logic                            fire_o
);
  import mdd_pkg::*;

  logic [SAMPLE_BITS-1:0] delta;

  assign delta  = (sample_i >= last_i) ? sample_i - last_i : last_i - sample_i;
  assign fire_o = CMP_BITS'(delta) > CMP_BITS'(thr_i);

endmodule

[rtl/mdd_ratio_div.sv]
// mdd_ratio_div: restoring divider for quiet * 2^16 / (fired + quiet), one bit a cycle
// depends on mdd_pkg for total and ratio widths and the status struct
`timescale 1ns / 1ps

module mdd_ratio_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mdd_pkg::TOTAL_BITS-1:0] fired_i,
  input  logic [mdd_pkg::TOTAL_BITS-1:0] quiet_i,
  output mdd_pkg::div_status_t           status_o,
  output logic [mdd_pkg::RATIO_BITS-1:0] ratio_o
);
  import mdd_pkg::*;

  logic                    busy_q, done_q;
  logic [DIV_CNT_BITS-1:0] cnt_q;
  logic [SUM_BITS-1:0]     sum_q, rem_q, rem_d;
  logic [RATIO_BITS-1:0]   quot_q;
  logic                    nbit_q;
  logic [SUM_BITS-1:0]     sum_w;
  logic [SUM_BITS+1:0]     trial;
  logic                    ge;

  assign sum_w = SUM_BITS'(fired_i) + SUM_BITS'(quiet_i);

  // remainder stays below the divisor, so one subtract decides each quotient bit
  assign trial = {1'b0, rem_q, nbit_q} - (SUM_BITS + 2)'(sum_q);
  assign ge    = ~trial[SUM_BITS+1];
  assign rem_d = ge ? trial[SUM_BITS-1:0] : {rem_q[SUM_BITS-2:0], nbit_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        if (sum_w == '0) begin
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
          cnt_q  <= DIV_CNT_BITS'(DIV_STEPS);
        end
      end else if (busy_q) begin
        cnt_q <= cnt_q - DIV_CNT_BITS'(1);
        if (cnt_q == DIV_CNT_BITS'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sum_q  <= sum_w;
      rem_q  <= SUM_BITS'(quiet_i >> 1);
      nbit_q <= quiet_i[0];
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      nbit_q <= 1'b0;
      quot_q <= {quot_q[RATIO_BITS-2:0], ge};
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign ratio_o       = quot_q;

endmodule

[rtl/mdd_checker.sv]
// mdd_checker: port-level assertions on the delta event detector, bound to the top level
// depends on mdd_pkg for the result type
`timescale 1ns / 1ps

module mdd_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input mdd_pkg::result_t out_payload_i
);
  import mdd_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result changed while stalled");

  // one vector at a time: no transfer right after a transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input ready right after a transfer");

  // a priming result carries no fires, empty totals and a zero ratio
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.priming_item |->
      out_payload_i.fired_mask == '0 && out_payload_i.fired_count == '0 &&
      out_payload_i.vectors_fired == '0 && out_payload_i.vectors_quiet == '0 &&
      out_payload_i.quiet_ratio == '0)
    else $error("priming result not empty");

  // fire count agrees with the mask
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> $countones(out_payload_i.fired_mask) ==
      int'(out_payload_i.fired_count))
    else $error("fire count does not match mask");

endmodule

bind multichannel_delta_event_detector mdd_checker u_mdd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (sample_i.valid),
  .in_ready_i    (sample_i.ready),
  .out_valid_i   (result_o.valid),
  .out_ready_i   (result_o.ready),
  .out_payload_i (result_o.payload)
);

[tb/tb_multichannel_delta_event_detector.sv]
// tb_multichannel_delta_event_detector: self-checking bench for the delta event detector
// drives sample vectors and threshold writes, predicts every result and compares field by field
// depends on mdd_pkg, the mdd channel interfaces and the detector top level
`timescale 1ns / 1ps

module tb_multichannel_delta_event_detector;
  import mdd_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int IDLE_PCT     = 17;
  localparam int RAND_PHASES  = 8;
  localparam int PHASE_ITEMS  = 250;

  typedef enum logic [1:0] {OP_VECTOR, OP_REG_WRITE, OP_SYNC} op_kind_e;

  typedef struct packed {
    op_kind_e                 kind;
    sample_t                  vec;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
  } op_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  mdd_sample_if sample_if ();
  mdd_result_if result_if ();
  mdd_cfg_if    cfg_if ();

  multichannel_delta_event_detector dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sample_i(sample_if),
    .result_o(result_if),
    .cfg_i   (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus queue and expected results
  op_t     pending_ops[$];
  result_t expected_results[$];

  // predictor state
  logic [THR_BITS-1:0]    thr_now[MAX_CH];
  logic [SAMPLE_BITS-1:0] prev_sample[MAX_CH];
  logic                   primed;
  logic [TOTAL_BITS-1:0]  fired_tot;
  logic [TOTAL_BITS-1:0]  quiet_tot;

  // generator state, tracks what was queued so deltas can be aimed at thresholds
  logic [THR_BITS-1:0]    gen_thr[MAX_CH];
  logic [SAMPLE_BITS-1:0] gen_last[MAX_CH];

  int total_transfers;
  int vectors_sent;
  int reg_writes;
  int results_checked;
  int fired_seen;
  int quiet_seen;
  int errors;
  int cycle_count;
  logic steady;

  // no idling on either side for a long stretch in the middle of the run
  assign steady = (vectors_sent >= 900) && (vectors_sent < 1300);

  function automatic result_t predict_delta(sample_t vec);
    samples_t             s;
    result_t              r;
    logic [SAMPLE_BITS-1:0] diff;
    logic [63:0]          sum;
    s = samples_t'(vec);
    r = '0;
    if (!primed) begin
      for (int ch = 0; ch < CHANNELS; ch++) prev_sample[ch] = s[ch];
      primed = 1'b1;
      r.priming_item = 1'b1;
    end else begin
      for (int ch = 0; ch < CHANNELS; ch++) begin
        diff = (s[ch] >= prev_sample[ch]) ? s[ch] - prev_sample[ch] : prev_sample[ch] - s[ch];
        if (diff > thr_now[ch]) begin
          r.fired_mask[ch] = 1'b1;
          r.fired_count    = r.fired_count + COUNT_BITS'(1);
        end
        prev_sample[ch] = s[ch];
      end
      if (r.fired_count != 0) fired_tot = (&fired_tot) ? fired_tot : fired_tot + TOTAL_BITS'(1);
      else                    quiet_tot = (&quiet_tot) ? quiet_tot : quiet_tot + TOTAL_BITS'(1);
    end
    r.vectors_fired = fired_tot;
    r.vectors_quiet = quiet_tot;
    sum = 64'(fired_tot) + 64'(quiet_tot);
    r.quiet_ratio = (sum == 0) ? '0 : RATIO_BITS'((64'(quiet_tot) << 16) / sum);
    return r;
  endfunction

  task automatic add_vector(input samples_t s);
    op_t op;
    op      = '0;
    op.kind = OP_VECTOR;
    op.vec  = sample_t'(s);
    pending_ops.push_back(op);
    for (int ch = 0; ch < MAX_CH; ch++) gen_last[ch] = s[ch];
    total_transfers++;
  endtask

  task automatic add_reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                               input logic [CFG_DATA_BITS-1:0] data);
    op_t op;
    op      = '0;
    op.kind = OP_REG_WRITE;
    op.idx  = idx;
    op.data = data;
    pending_ops.push_back(op);
    if (idx < NUM_REGS) gen_thr[CH_IDX_BITS'(idx)] = data;
    total_transfers++;
  endtask

  task automatic add_sync();
    op_t op;
    op      = '0;
    op.kind = OP_SYNC;
    pending_ops.push_back(op);
  endtask

  task automatic set_all_thresholds(input logic [CFG_DATA_BITS-1:0] data);
    for (int ch = 0; ch < MAX_CH; ch++) add_reg_write(CFG_IDX_BITS'(REG_THRESHOLD_CH0 + ch), data);
  endtask

  function automatic logic [THR_BITS-1:0] pick_threshold();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 10)      return '0;
    else if (roll < 15) return '1;
    else if (roll < 70) return THR_BITS'($urandom_range(0, 8000));
    else                return THR_BITS'($urandom());
  endfunction

  task automatic add_random_vector();
    samples_t s;
    int       last, t, delta, val, roll;
    logic     calm;
    calm = ($urandom_range(0, 99) < 40);
    for (int ch = 0; ch < MAX_CH; ch++) begin
      last  = int'(gen_last[ch]);
      t     = int'(gen_thr[ch]);
      roll  = calm ? 10 : $urandom_range(0, 9);
      delta = -1;
      val   = last;
      case (roll)
        0, 1:    val = last;
        2, 3:    delta = t + $urandom_range(0, 1);   // right on the threshold edge
        4, 5, 6: delta = $urandom_range(0, 2 * t + 2);
        10:      delta = $urandom_range(0, t);
        default: val = $urandom_range(0, 65535);
      endcase
      if (delta >= 0) begin
        val = $urandom_range(0, 1) ? last + delta : last - delta;
        if (val > 65535) val = 65535;
        if (val < 0)     val = 0;
      end
      s[ch] = SAMPLE_BITS'(val);
    end
    add_vector(s);
  endtask

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  // reset and known input levels from time zero
  initial begin
    rst_ni            = 1'b0;
    sample_if.valid   = 1'b0;
    sample_if.payload = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = '0;
    cfg_if.data       = '0;
    result_if.ready   = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // sample and register-write driver
  always @(posedge clk_i) begin : drive_proc
    op_t  nxt;
    logic s_valid;
    logic c_valid;
    if (!rst_ni) begin
      sample_if.valid <= 1'b0;
      cfg_if.valid    <= 1'b0;
    end else begin
      s_valid = sample_if.valid;
      c_valid = cfg_if.valid;
      if (s_valid && sample_if.ready) begin
        expected_results.push_back(predict_delta(sample_if.payload));
        vectors_sent++;
        s_valid = 1'b0;
      end
      if (c_valid && cfg_if.ready) begin
        if (cfg_if.index < NUM_REGS) thr_now[CH_IDX_BITS'(cfg_if.index)] = cfg_if.data;
        reg_writes++;
        c_valid = 1'b0;
      end
      if (!s_valid && !c_valid) begin
        // a sync point holds back register writes until every result is out
        while (pending_ops.size() > 0 && pending_ops[0].kind == OP_SYNC &&
               expected_results.size() == 0)
          void'(pending_ops.pop_front());
        if (pending_ops.size() > 0 && pending_ops[0].kind != OP_SYNC &&
            (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
          nxt = pending_ops.pop_front();
          if (nxt.kind == OP_VECTOR) begin
            s_valid = 1'b1;
            sample_if.payload <= nxt.vec;
          end else begin
            c_valid = 1'b1;
            cfg_if.index <= nxt.idx;
            cfg_if.data  <= nxt.data;
          end
        end
      end
      sample_if.valid <= s_valid;
      cfg_if.valid    <= c_valid;
    end
  end

  // result backpressure
  always @(posedge clk_i) begin
    if (!rst_ni) result_if.ready <= 1'b0;
    else         result_if.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result monitor
  always @(posedge clk_i) begin : check_proc
    result_t want;
    result_t got;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got = result_if.payload;
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %h", $time, got);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("fired_mask",    64'(want.fired_mask),    64'(got.fired_mask));
        check_field("fired_count",   64'(want.fired_count),   64'(got.fired_count));
        check_field("priming_item",  64'(want.priming_item),  64'(got.priming_item));
        check_field("vectors_fired", 64'(want.vectors_fired), 64'(got.vectors_fired));
        check_field("vectors_quiet", 64'(want.vectors_quiet), 64'(got.vectors_quiet));
        check_field("quiet_ratio",   64'(want.quiet_ratio),   64'(got.quiet_ratio));
        results_checked++;
        if (!want.priming_item) begin
          if (want.fired_count != 0) fired_seen++;
          else                       quiet_seen++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("tb_multichannel_delta_event_detector: FAIL");
      $finish;
    end
  end

  initial begin : stimulus_proc
    samples_t s;
    primed    = 1'b0;
    fired_tot = '0;
    quiet_tot = '0;
    for (int ch = 0; ch < MAX_CH; ch++) begin
      thr_now[ch]     = THR_RESET[ch];
      gen_thr[ch]     = THR_RESET[ch];
      prev_sample[ch] = '0;
      gen_last[ch]    = '0;
    end

    // reset thresholds: priming, full-scale swings, exact threshold and one past it
    for (int ch = 0; ch < MAX_CH; ch++) s[ch] = '1;
    add_vector(s);
    for (int ch = 0; ch < MAX_CH; ch++) s[ch] = '0;
    add_vector(s);
    add_vector(s);
    for (int ch = 0; ch < MAX_CH; ch++) s[ch] = THR_RESET[ch];
    add_vector(s);
    for (int ch = 0; ch < MAX_CH; ch++) s[ch] = SAMPLE_BITS'(2 * THR_RESET[ch] + 1);
    add_vector(s);
    // one channel at a time steps back by threshold plus one
    for (int k = 0; k < MAX_CH; k++) begin
      s[k] = THR_RESET[k];
      add_vector(s);
    end
    for (int ch = 0; ch < MAX_CH; ch++) s[ch] = 16'hAAAA;
    add_vector(s);
    for (int ch = 0; ch < MAX_CH; ch++) s[ch] = 16'h5555;
    add_vector(s);

    // zero thresholds: any change fires, out-of-range writes must be ignored
    add_sync();
    set_all_thresholds('0);
    add_reg_write(CFG_IDX_BITS'(NUM_REGS), '1);
    add_reg_write('1, '1);
    add_vector(s);
    for (int ch = 0; ch < MAX_CH; ch++) s[ch] = SAMPLE_BITS'(16'h5555 + (ch % 2));
    add_vector(s);

    // full-scale thresholds: nothing can fire
    add_sync();
    set_all_thresholds('1);
    for (int ch = 0; ch < MAX_CH; ch++) s[ch] = '0;
    add_vector(s);
    for (int ch = 0; ch < MAX_CH; ch++) s[ch] = '1;
    add_vector(s);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      add_sync();
      for (int ch = 0; ch < MAX_CH; ch++)
        add_reg_write(CFG_IDX_BITS'(REG_THRESHOLD_CH0 + ch), pick_threshold());
      if ($urandom_range(0, 1))
        add_reg_write(CFG_IDX_BITS'($urandom_range(NUM_REGS, 2 ** CFG_IDX_BITS - 1)),
                      CFG_DATA_BITS'($urandom()));
      repeat (PHASE_ITEMS) add_random_vector();
    end

    wait (rst_ni);
    do @(posedge clk_i);
    while (vectors_sent + reg_writes < total_transfers || expected_results.size() > 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      errors++;
    end

    $display("checked %0d results from %0d vectors: %0d with fires, %0d quiet, %0d mismatches",
             results_checked, vectors_sent, fired_seen, quiet_seen, errors);
    $display("threshold sets: reset, all zero, all full scale and %0d random (%0d reg transfers)",
             RAND_PHASES, reg_writes);
    if (errors == 0) begin
      $display("tb_multichannel_delta_event_detector: PASS");
    end else begin
      $display("tb_multichannel_delta_event_detector: FAIL");
    end
    $finish;
  end

endmodule

[multichannel_delta_event_detector.f]
rtl/mdd_pkg.sv
rtl/mdd_if.sv
rtl/mdd_delta_unit.sv
rtl/mdd_ratio_div.sv
rtl/multichannel_delta_event_detector.sv
rtl/mdd_checker.sv
tb/tb_multichannel_delta_event_detector.sv
